[hw/rtl/perlin_noise_2d_unit_assert.svh]
// Assertion macros for the perlin noise unit.
// Needs a clock named clk and a reset named rst in the module that uses them.
`ifndef PERLIN_NOISE_2D_UNIT_ASSERT_SVH
`define PERLIN_NOISE_2D_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define PND_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnd assertion failed");

// Implication checked in the following cycle.
`define PND_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnd assertion failed");

`endif

[hw/rtl/pnd_pkg.sv]
// Shared constants for the perlin noise unit: default fraction width, queue
// depth, output width, the permutation table and the queue status type. No dependencies.
`default_nettype none
package pnd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int OUT_W         = 18;

  // Entry 256 of the classic table repeats entry 0, so an 8-bit wrap serves.
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  // Queue status (full, empty) seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

[hw/rtl/pnd_front.sv]
// Front end: registers the coordinates, splits cell and fraction, hashes
// the x corners and pushes into the queue. Depends on pnd_pkg.
`default_nettype none
module pnd_front #(
  parameter int FRAC_BITS = pnd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    accept,
  input  wire logic signed [31:0]      coord_x,
  input  wire logic signed [31:0]      coord_y,
  output logic                         push,
  output logic [2*FRAC_BITS+15:0]      push_data
);

  logic                 vld;
  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [7:0]           cx;
  logic [7:0]           cy;
  logic [7:0]           ha;
  logic [7:0]           hb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fx <= coord_x[FRAC_BITS-1:0];
    fy <= coord_y[FRAC_BITS-1:0];
    cx <= coord_x[FRAC_BITS+7:FRAC_BITS];
    cy <= coord_y[FRAC_BITS+7:FRAC_BITS];
  end

  // Hash the two x corners; the add wraps at 8 bits
  always_comb begin
    ha = pnd_pkg::PERM[cx] + cy;
    hb = pnd_pkg::PERM[cx + 8'd1] + cy;
  end

  assign push      = vld;
  assign push_data = {fx, fy, ha, hb};

endmodule
`default_nettype wire

[hw/rtl/pnd_queue.sv]
// Short register queue between front and back ends.
// Depends on pnd_pkg and perlin_noise_2d_unit_assert.svh.
`default_nettype none
`include "perlin_noise_2d_unit_assert.svh"
module pnd_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = pnd_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output pnd_pkg::qstat_t       stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

  `PND_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `PND_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count == $past(count) + 1'b1)
  `PND_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count == $past(count) - 1'b1)
  `PND_ASSERT_NOW(a_ptr_match, (count != '0) && (count != CW'(DEPTH)), wr_ptr != rd_ptr)

endmodule
`default_nettype wire

[hw/rtl/pnd_back.sv]
// Back end: fade curves, corner gradients and bilinear blend over five
// register stages, then output scaling and clamp. Depends on pnd_pkg.
`default_nettype none
module pnd_back #(
  parameter int FRAC_BITS = pnd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_vld,
  input  wire logic [2*FRAC_BITS+15:0]   in_data,
  output logic                           out_vld,
  output logic signed [pnd_pkg::OUT_W-1:0] out_value
);

  localparam int F   = FRAC_BITS;
  localparam int GW  = F + 2;   // gradient and blend width
  localparam int DW  = F + 3;   // difference width
  localparam int QW  = F + 4;   // fade polynomial width
  localparam int RSH = (F >= 16) ? F - 16 : 0;
  localparam int LSH = (F < 16) ? 16 - F : 0;
  localparam int WW  = 40;
  localparam logic [QW-1:0] TEN_S = QW'(10) << F;
  localparam logic signed [WW-1:0] OMAX = WW'(131071);
  localparam logic signed [WW-1:0] OMIN = -WW'(131072);

  logic [4:0] vld;

  // stage 1
  logic [F-1:0]  s1_fx, s1_fy, s1_t2x, s1_t2y;
  logic [1:0]    s1_h00, s1_h10, s1_h01, s1_h11;
  // stage 2
  logic [F-1:0]  s2_fx, s2_fy, s2_t3x, s2_t3y;
  logic [QW-1:0] s2_qx, s2_qy;
  logic [1:0]    s2_h00, s2_h10, s2_h01, s2_h11;
  // stage 3
  logic [F-1:0]  s3_u, s3_v;
  logic signed [GW-1:0] s3_g00, s3_g10, s3_g01, s3_g11;
  // stage 4
  logic [F-1:0]  s4_v;
  logic signed [GW-1:0] s4_a, s4_b;

  logic [7:0] ha, hb;
  logic [F-1:0] in_fx, in_fy;
  logic [2*F-1:0] sqx, sqy, cbx, cby;
  logic [2*F+3:0] fdx, fdy;

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
      input logic signed [GW-1:0] dx, input logic signed [GW-1:0] dy);
    logic signed [GW:0] gx;
    logic signed [GW:0] gy;
    logic signed [GW:0] s;
    gx = h[0] ? -{dx[GW-1], dx} : {dx[GW-1], dx};
    gy = h[1] ? -{dy[GW-1], dy} : {dy[GW-1], dy};
    s  = gx + gy;
    return s[GW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] blend(input logic [F-1:0] w,
      input logic signed [GW-1:0] a, input logic signed [GW-1:0] b);
    logic signed [DW-1:0]    d;
    logic signed [F+DW:0]    p;
    logic signed [F+DW:0]    sh;
    logic signed [GW-1:0]    r;
    d  = DW'(b) - DW'(a);
    p  = $signed({1'b0, w}) * d;
    sh = p >>> F;
    r  = a + sh[GW-1:0];
    return r;
  endfunction

  assign {in_fx, in_fy, ha, hb} = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_vld};
    end
  end

  // Stage 1: squares of the fractions and the corner gradient selects
  assign sqx = in_fx * in_fx;
  assign sqy = in_fy * in_fy;
  always_ff @(posedge clk) begin
    s1_fx  <= in_fx;
    s1_fy  <= in_fy;
    s1_t2x <= sqx[2*F-1:F];
    s1_t2y <= sqy[2*F-1:F];
    s1_h00 <= pnd_pkg::PERM[ha][1:0];
    s1_h10 <= pnd_pkg::PERM[hb][1:0];
    s1_h01 <= pnd_pkg::PERM[ha + 8'd1][1:0];
    s1_h11 <= pnd_pkg::PERM[hb + 8'd1][1:0];
  end

  // Stage 2: cubes and the quadratic factor of the fade
  assign cbx = s1_t2x * s1_fx;
  assign cby = s1_t2y * s1_fy;
  always_ff @(posedge clk) begin
    s2_fx  <= s1_fx;
    s2_fy  <= s1_fy;
    s2_t3x <= cbx[2*F-1:F];
    s2_t3y <= cby[2*F-1:F];
    s2_qx  <= QW'(6) * QW'(s1_t2x) + TEN_S - QW'(15) * QW'(s1_fx);
    s2_qy  <= QW'(6) * QW'(s1_t2y) + TEN_S - QW'(15) * QW'(s1_fy);
    s2_h00 <= s1_h00;
    s2_h10 <= s1_h10;
    s2_h01 <= s1_h01;
    s2_h11 <= s1_h11;
  end

  // Stage 3: fade weights and the four corner gradients
  assign fdx = s2_t3x * s2_qx;
  assign fdy = s2_t3y * s2_qy;
  always_ff @(posedge clk) begin
    s3_u   <= fdx[2*F-1:F];
    s3_v   <= fdy[2*F-1:F];
    s3_g00 <= grad(s2_h00, GW'(s2_fx), GW'(s2_fy));
    s3_g10 <= grad(s2_h10, GW'(s2_fx) - (GW'(1) << F), GW'(s2_fy));
    s3_g01 <= grad(s2_h01, GW'(s2_fx), GW'(s2_fy) - (GW'(1) << F));
    s3_g11 <= grad(s2_h11, GW'(s2_fx) - (GW'(1) << F), GW'(s2_fy) - (GW'(1) << F));
  end

  // Stage 4: blend along x
  always_ff @(posedge clk) begin
    s4_v <= s3_v;
    s4_a <= blend(s3_u, s3_g00, s3_g10);
    s4_b <= blend(s3_u, s3_g01, s3_g11);
  end

  // Stage 5: blend along y, rescale to 16 fraction bits, clamp
  logic signed [GW-1:0] r;
  logic signed [WW-1:0] rw;
  logic signed [WW-1:0] rs;
  always_comb begin
    r  = blend(s4_v, s4_a, s4_b);
    rw = WW'(r);
    rs = (rw <<< LSH) >>> RSH;
    if (rs > OMAX) begin
      rs = OMAX;
    end else if (rs < OMIN) begin
      rs = OMIN;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= rs[pnd_pkg::OUT_W-1:0];
  end

  assign out_vld = vld[4];

endmodule
`default_nettype wire

[hw/rtl/perlin_noise_2d_unit.sv]
// Top level of the 2D gradient noise unit: front end, queue, back end.
// Depends on pnd_pkg, pnd_front, pnd_queue and pnd_back.
`default_nettype none
// Usage:
//   Drive coord_x and coord_y (signed, FRAC_BITS fraction bits) and raise
//   start; the item is taken at a clock edge where start is high and busy
//   is low. Hold start high to stream one coordinate pair per clock while
//   busy is low. The noise sample appears on noise_value (signed, 16
//   fraction bits) with done high for exactly one cycle, once the item has
//   passed the front register, the queue and the back-end stages; results
//   leave in the order items came in.
//   Throughput: one item per clock, sustained while busy is low. The front
//   end registers and hashes the lattice cell, the queue hands it to a
//   five-stage back end that never stalls, so the queue holds at most one item
//   and busy stays low in normal use; busy rises only if the queue were to fill.
//   The receiver cannot hold results off: take done and noise_value in the
//   cycle they are shown.
//   Reset (rst, synchronous, active high) drops every item in flight and
//   empties the queue; no result follows an item taken before reset.
module perlin_noise_2d_unit #(
  parameter int FRAC_BITS = pnd_pkg::FRAC_BITS_DEF,
  parameter int DEPTH     = pnd_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [31:0]            coord_x,
  input  wire logic signed [31:0]            coord_y,
  output logic                               done,
  output logic signed [pnd_pkg::OUT_W-1:0]   noise_value
);

  localparam int QW = 2 * FRAC_BITS + 16;

  logic            accept;
  logic            push;
  logic [QW-1:0]   push_data;
  logic [QW-1:0]   pop_data;
  logic            pop;
  pnd_pkg::qstat_t stat;
  logic            front_busy;

  // Registered flag: queue full, or a push with no pop; busy needs it and a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      front_busy <= 1'b0;
    end else begin
      front_busy <= stat.full || (push && !pop);
    end
  end

  assign busy   = front_busy && stat.full;
  assign accept = start && !busy;
  // Advance the back end whenever the queue holds an item
  assign pop    = !stat.empty;

  pnd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .push      (push),
    .push_data (push_data)
  );

  pnd_queue #(.WIDTH(QW), .DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  pnd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (pop),
    .in_data   (pop_data),
    .out_vld   (done),
    .out_value (noise_value)
  );

endmodule
`default_nettype wire

[test/perlin_noise_2d_unit_test.sv]
// Testbench for perlin_noise_2d_unit: drives coordinate pairs and checks every noise sample
// against a bit-exact predictor held in a small scoreboard class. Depends on pnd_pkg and the RTL.
`default_nettype none
module perlin_noise_2d_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB       = pnd_pkg::FRAC_BITS_DEF;
  localparam int OW       = pnd_pkg::OUT_W;
  localparam int N_RANDOM = 1500;
  localparam int WD_LIMIT = 2000;
  localparam int DRAIN    = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic busy, done;
  logic signed [OW-1:0] noise_value;

  int n_errors = 0;
  int n_taken = 0;
  int n_checked = 0;
  int idle_cycles = 0;

  perlin_noise_2d_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .done(done), .noise_value(noise_value)
  );

  always #5 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  // Holds the expected noise samples in item order and predicts each from its coordinates.
  class noise_board;
    logic signed [OW-1:0] pending[$];

    // floor(v / 2^FB), arithmetic shift floors toward minus infinity
    function automatic longint fl_shr(longint v);
      return v >>> FB;
    endfunction

    function automatic longint fade(longint f);
      longint t2, t3, q;
      t2 = (f * f) >>> FB;
      t3 = (t2 * f) >>> FB;
      q = 6 * t2 - 15 * f + 10 * (longint'(1) << FB);
      if (q < 0) q = 0;
      return (t3 * q) >>> FB;
    endfunction

    function automatic longint grad(logic [7:0] h, longint dx, longint dy);
      return (h[0] ? -dx : dx) + (h[1] ? -dy : dy);
    endfunction

    function automatic longint blend(longint w, longint a, longint b);
      return a + fl_shr(w * (b - a));
    endfunction

    function automatic logic [7:0] perm(int idx);
      return pnd_pkg::PERM[idx & 8'hff];   // entry 256 repeats entry 0
    endfunction

    function automatic logic signed [OW-1:0] predict(logic [31:0] x, logic [31:0] y);
      int cx, cy, ha, hb;
      longint fx, fy, u, v, one, g00, g10, g01, g11, r;
      one = longint'(1) << FB;
      cx = (x >> FB) & 8'hff;
      cy = (y >> FB) & 8'hff;
      fx = longint'(x & ((32'd1 << FB) - 1));
      fy = longint'(y & ((32'd1 << FB) - 1));
      u = fade(fx);
      v = fade(fy);
      ha = (perm(cx) + cy) & 8'hff;
      hb = (perm(cx + 1) + cy) & 8'hff;
      g00 = grad(perm(ha), fx, fy);
      g10 = grad(perm(hb), fx - one, fy);
      g01 = grad(perm(ha + 1), fx, fy - one);
      g11 = grad(perm(hb + 1), fx - one, fy - one);
      r = blend(v, blend(u, g00, g10), blend(u, g01, g11));
      if (FB >= 16) r = r >>> (FB - 16);
      else r = r <<< (16 - FB);
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[OW-1:0];
    endfunction

    function void note_item(logic [31:0] x, logic [31:0] y);
      pending.push_back(predict(x, y));
    endfunction

    task check_sample(logic signed [OW-1:0] got);
      logic signed [OW-1:0] want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("noise_value %0d with no item outstanding", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want)
        report_mismatch($sformatf("noise_value got %0d want %0d", got, want));
    endtask
  endclass

  noise_board board = new();

  // Sample both handshakes at the rising edge; watchdog counts cycles with nothing accepted and no sample done.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_item(coord_x, coord_y);
        n_taken++;
      end
      if (done) begin
        board.check_sample(noise_value);
        n_checked++;
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles", WD_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one item from the falling edge on; hold it until taken. Sometimes idle first if allowed.
  // busy only moves at the rising edge, so its value at the falling edge holds for the next one.
  task automatic send_item(input logic [31:0] x, input logic [31:0] y, input bit allow_gap);
    if (allow_gap && $urandom_range(99) < 6) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Random coordinate: half near the origin, a quarter fully random, a quarter on lattice edges.
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(3))
      0: c = $urandom();
      1: c = {{8{1'b0}}, 24'($urandom())} - 32'h0080_0000;
      2: c = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: begin
        c = $urandom();
        c[15:0] = $urandom_range(1) ? 16'h0000 : 16'hffff;
      end
    endcase
    return c;
  endfunction

  initial begin
    logic [31:0] edges[$];
    edges = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
              32'h0000_ffff, 32'h0001_0000, 32'h00ff_8000};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes, cells where index 255 wraps, a half-way point and alternating bit patterns.
    foreach (edges[i]) send_item(edges[i], edges[(i + 3) % edges.size()], 1'b0);
    send_item(32'h00ff_0000, 32'h00ff_0000, 1'b0);
    send_item(32'h00ff_ffff, 32'h00ff_ffff, 1'b0);
    send_item(32'h0000_8000, 32'h0000_8000, 1'b0);
    send_item(32'hffff_0000, 32'h0000_0001, 1'b0);
    send_item(32'h5555_5555, 32'haaaa_aaaa, 1'b0);
    send_item(32'haaaa_aaaa, 32'h5555_5555, 1'b0);

    // Random: a stretch with no idling, then idling now and again.
    for (int i = 0; i < N_RANDOM; i++)
      send_item(rand_coord(), rand_coord(), i >= 300);
    start <= 1'b0;

    wait (board.pending.size() == 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d items, %0d samples checked (extremes, wrap cells, random)",
             n_taken, n_checked);
    if (n_errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
